// ----- hdl/pfla_pkg.sv -----
// shared widths, defaults, command codes and the free-run table entry type
package pfla_pkg;

  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned PAGES_W = 36;
  localparam int unsigned CMD_W   = 2;

  localparam int unsigned TABLE_ENTRIES_DEF = 256;
  localparam int unsigned PAGE_BYTES_DEF    = 4096;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PUSH  = 2'd1,
    CMD_MERGE = 2'd2,
    CMD_ALLOC = 2'd3
  } cmd_e;

  typedef struct packed {
    logic               valid;
    logic [PAGES_W-1:0] pages;
    logic [ADDR_W-1:0]  base;
  } run_t;

endpackage

// ----- hdl/page_free_list_allocator_core.sv -----
// first-fit page run allocator: command sequencer around the run table memory
//
//   channel   ports                                          handshake
//   command   command_i, block_base_i, page_count_i          start_i high, busy_o low
//   result    success_o, alloc_address_o                     done_o for one cycle
//
// push and allocate read one entry a cycle and stop at the first entry that fits
// clear writes every entry before its result beat
// merge rescans the whole table once per valid run
// the single table read port paces every command
// after reset the table is swept with busy_o high
// results cannot be held off; done_o marks each one-cycle beat
module page_free_list_allocator_core #(
  parameter int unsigned TABLE_ENTRIES = pfla_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned PAGE_BYTES    = pfla_pkg::PAGE_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pfla_pkg::CMD_W-1:0]   command_i,
  input  logic [pfla_pkg::ADDR_W-1:0]  block_base_i,
  input  logic [pfla_pkg::PAGES_W-1:0] page_count_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic                         success_o,
  output logic [pfla_pkg::ADDR_W-1:0]  alloc_address_o
);

  localparam int unsigned AW   = pfla_pkg::ADDR_W;
  localparam int unsigned PW   = pfla_pkg::PAGES_W;
  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [CntW-1:0] CntEnd  = CntW'(TABLE_ENTRIES);
  localparam logic [CntW-1:0] CntLast = CntW'(TABLE_ENTRIES - 1);
  localparam logic [AW-1:0]   PageBytesW = AW'(PAGE_BYTES);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_PUSH,
    ST_ALLOC,
    ST_OUTER,
    ST_INNER
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic              done_q, done_d;
  logic              success_q, success_d;
  logic [AW-1:0]     addr_q, addr_d;

  logic [IdxW-1:0]   pend_idx_q;
  logic [IdxW-1:0]   a_idx_q, a_idx_d;
  logic [AW-1:0]     a_base_q, a_base_d;
  logic [PW-1:0]     a_pages_q, a_pages_d;
  logic [AW-1:0]     a_end_q, a_end_d;
  logic [AW-1:0]     in_base_q, in_base_d;
  logic [PW-1:0]     in_pages_q, in_pages_d;
  logic [AW-1:0]     want_span_q, want_span_d;

  logic              issue;
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  pfla_pkg::run_t    mem_wdata;
  pfla_pkg::run_t    rd;

  logic [AW-1:0]     rd_end;
  logic [PW:0]       total;
  logic              total_fits;
  logic              scan_end;
  logic [PW-1:0]     left_pages;

  pfla_mem #(
    .DEPTH (TABLE_ENTRIES)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (issue),
    .raddr_i (cnt_q[IdxW-1:0]),
    .rdata_o (rd)
  );

  assign rd_end     = rd.base + (AW'(rd.pages) * PageBytesW);
  assign total      = {1'b0, a_pages_q} + {1'b0, rd.pages};
  assign total_fits = ~total[PW];
  assign scan_end   = ~pend_q && (cnt_q == CntEnd);
  assign left_pages = rd.pages - in_pages_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    done_d      = 1'b0;
    success_d   = success_q;
    addr_d      = addr_q;
    a_idx_d     = a_idx_q;
    a_base_d    = a_base_q;
    a_pages_d   = a_pages_q;
    a_end_d     = a_end_q;
    in_base_d   = in_base_q;
    in_pages_d  = in_pages_q;
    want_span_d = want_span_q;
    issue       = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = pend_idx_q;
    mem_wdata   = rd;

    case (state_q)
      ST_INIT, ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[IdxW-1:0];
        mem_wdata = '0;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = ST_IDLE;
          if (state_q == ST_CLEAR) begin
            done_d    = 1'b1;
            success_d = 1'b1;
            addr_d    = '0;
          end
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cnt_d       = '0;
          in_base_d   = block_base_i;
          in_pages_d  = page_count_i;
          want_span_d = AW'(page_count_i) * PageBytesW;
          case (pfla_pkg::cmd_e'(command_i))
            pfla_pkg::CMD_CLEAR: state_d = ST_CLEAR;
            pfla_pkg::CMD_PUSH:  state_d = ST_PUSH;
            pfla_pkg::CMD_MERGE: state_d = ST_OUTER;
            pfla_pkg::CMD_ALLOC: state_d = ST_ALLOC;
            default:             state_d = ST_IDLE;
          endcase
        end
      end
      ST_PUSH: begin
        issue = (cnt_q != CntEnd);
        if (pend_q && !rd.valid) begin
          issue     = 1'b0;
          mem_we    = 1'b1;
          mem_wdata = '{valid: 1'b1, pages: in_pages_q, base: in_base_q};
          state_d   = ST_IDLE;
          done_d    = 1'b1;
          success_d = 1'b1;
          addr_d    = '0;
        end else if (scan_end) begin
          state_d   = ST_IDLE;
          done_d    = 1'b1;
          success_d = 1'b0;
          addr_d    = '0;
        end
      end
      ST_ALLOC: begin
        issue = (cnt_q != CntEnd);
        if (pend_q && rd.valid && (rd.pages >= in_pages_q)) begin
          issue     = 1'b0;
          mem_we    = 1'b1;
          mem_wdata = '{valid: (left_pages != '0), pages: left_pages,
                        base: rd.base + want_span_q};
          state_d   = ST_IDLE;
          done_d    = 1'b1;
          success_d = 1'b1;
          addr_d    = rd.base;
        end else if (scan_end) begin
          state_d   = ST_IDLE;
          done_d    = 1'b1;
          success_d = 1'b0;
          addr_d    = '0;
        end
      end
      ST_OUTER: begin
        issue = (cnt_q != CntEnd);
        if (pend_q && rd.valid) begin
          issue     = 1'b0;
          a_idx_d   = pend_idx_q;
          a_base_d  = rd.base;
          a_pages_d = rd.pages;
          a_end_d   = rd_end;
          cnt_d     = '0;
          state_d   = ST_INNER;
        end else if (scan_end) begin
          state_d   = ST_IDLE;
          done_d    = 1'b1;
          success_d = 1'b1;
          addr_d    = '0;
        end
      end
      ST_INNER: begin
        issue = (cnt_q != CntEnd);
        if (pend_q && rd.valid && (pend_idx_q != a_idx_q) && total_fits) begin
          // joined entry is dropped; the held run stays in registers until the sweep ends
          if (a_end_q == rd.base) begin
            a_pages_d       = total[PW-1:0];
            a_end_d         = rd_end;
            mem_we          = 1'b1;
            mem_wdata.valid = 1'b0;
          end else if (rd_end == a_base_q) begin
            a_base_d        = rd.base;
            a_pages_d       = total[PW-1:0];
            mem_we          = 1'b1;
            mem_wdata.valid = 1'b0;
          end
        end else if (scan_end) begin
          mem_we    = 1'b1;
          mem_waddr = a_idx_q;
          mem_wdata = '{valid: 1'b1, pages: a_pages_q, base: a_base_q};
          cnt_d     = {1'b0, a_idx_q} + 1'b1;
          state_d   = ST_OUTER;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    pend_d = issue;
    if (issue) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      done_q    <= 1'b0;
      success_q <= 1'b0;
      addr_q    <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      done_q    <= done_d;
      success_q <= success_d;
      addr_q    <= addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q  <= cnt_q[IdxW-1:0];
    a_idx_q     <= a_idx_d;
    a_base_q    <= a_base_d;
    a_pages_q   <= a_pages_d;
    a_end_q     <= a_end_d;
    in_base_q   <= in_base_d;
    in_pages_q  <= in_pages_d;
    want_span_q <= want_span_d;
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign success_o       = success_q;
  assign alloc_address_o = addr_q;

endmodule

// ----- hdl/pfla_mem.sv -----
// free-run table storage: one write port, one read port with registered data
module pfla_mem #(
  parameter int unsigned DEPTH = pfla_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  pfla_pkg::run_t           wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output pfla_pkg::run_t           rdata_o
);

  pfla_pkg::run_t mem_q [DEPTH];
  pfla_pkg::run_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- tb/tb_top.sv -----
// testbench for page_free_list_allocator_core: random command beats checked against a table model
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TE = pfla_pkg::TABLE_ENTRIES_DEF;
  localparam int unsigned PB = pfla_pkg::PAGE_BYTES_DEF;
  localparam int unsigned ADDR_W = pfla_pkg::ADDR_W;
  localparam int unsigned PAGES_W = pfla_pkg::PAGES_W;
  localparam int unsigned NUM_ITEMS = 850;
  localparam int unsigned MAX_GAP = 400;
  localparam logic [PAGES_W-1:0] PAGES_MAX = '1;
  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
  localparam logic [ADDR_W-1:0] TOP_PAGE = 48'hFFFF_FFFF_F000;

  typedef struct {
    pfla_pkg::cmd_e     cmd;
    logic [ADDR_W-1:0]  base;
    logic [PAGES_W-1:0] pages;
  } page_cmd_t;

  typedef struct {
    logic              success;
    logic [ADDR_W-1:0] addr;
  } alloc_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start_i = 1'b0;
  logic [pfla_pkg::CMD_W-1:0] command_i = '0;
  logic [ADDR_W-1:0]          block_base_i = '0;
  logic [PAGES_W-1:0]         page_count_i = '0;
  logic                       busy_o;
  logic                       done_o;
  logic                       success_o;
  logic [ADDR_W-1:0]          alloc_address_o;

  page_cmd_t      pending_cmds[$];
  alloc_result_t  expected_results[$];
  pfla_pkg::run_t free_runs[TE];

  int          mismatches = 0;
  longint      cycle_count = 0;
  longint      cycle_budget = 0;
  int unsigned live_bound = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  logic [ADDR_W-1:0] cluster_lo, cluster_hi;

  page_free_list_allocator_core #(
    .TABLE_ENTRIES(TE),
    .PAGE_BYTES   (PB)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .command_i      (command_i),
    .block_base_i   (block_base_i),
    .page_count_i   (page_count_i),
    .busy_o         (busy_o),
    .done_o         (done_o),
    .success_o      (success_o),
    .alloc_address_o(alloc_address_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {16'($urandom), $urandom};
  endfunction

  function automatic logic [PAGES_W-1:0] rand_pages();
    return {4'($urandom), $urandom};
  endfunction

  function automatic logic [ADDR_W-1:0] run_end(input logic [ADDR_W-1:0] b,
                                                input logic [PAGES_W-1:0] p);
    logic [63:0] span;
    span = 64'(p) * 64'(PB);
    return b + span[ADDR_W-1:0];
  endfunction

  function automatic alloc_result_t predict_outcome(input page_cmd_t c);
    alloc_result_t r;
    logic [ADDR_W-1:0] a_end, b_end;
    logic [PAGES_W:0] total;
    logic found;
    r.success = 1'b1;
    r.addr = '0;
    found = 1'b0;
    case (c.cmd)
      pfla_pkg::CMD_CLEAR: begin
        foreach (free_runs[s]) free_runs[s].valid = 1'b0;
      end
      pfla_pkg::CMD_PUSH: begin
        for (int s = 0; s < TE && !found; s++) begin
          if (!free_runs[s].valid) begin
            free_runs[s] = '{valid: 1'b1, pages: c.pages, base: c.base};
            found = 1'b1;
          end
        end
        r.success = found;
      end
      pfla_pkg::CMD_MERGE: begin
        for (int a = 0; a < TE; a++) begin
          if (!free_runs[a].valid) continue;
          a_end = run_end(free_runs[a].base, free_runs[a].pages);
          for (int b = 0; b < TE; b++) begin
            if (a == b || !free_runs[b].valid) continue;
            b_end = run_end(free_runs[b].base, free_runs[b].pages);
            total = {1'b0, free_runs[a].pages} + {1'b0, free_runs[b].pages};
            // joins whose page sum overflows are skipped
            if (total[PAGES_W]) continue;
            if (a_end == free_runs[b].base) begin
              free_runs[a].pages = total[PAGES_W-1:0];
              free_runs[b].valid = 1'b0;
              a_end = run_end(free_runs[a].base, free_runs[a].pages);
            end else if (b_end == free_runs[a].base) begin
              free_runs[a].base = free_runs[b].base;
              free_runs[a].pages = total[PAGES_W-1:0];
              free_runs[b].valid = 1'b0;
              a_end = run_end(free_runs[a].base, free_runs[a].pages);
            end
          end
        end
      end
      default: begin
        for (int s = 0; s < TE && !found; s++) begin
          if (free_runs[s].valid && free_runs[s].pages >= c.pages) begin
            r.addr = free_runs[s].base;
            free_runs[s].base = run_end(free_runs[s].base, c.pages);
            free_runs[s].pages = free_runs[s].pages - c.pages;
            if (free_runs[s].pages == '0) free_runs[s].valid = 1'b0;
            found = 1'b1;
          end
        end
        r.success = found;
      end
    endcase
    return r;
  endfunction

  // queues one beat and widens the cycle budget by its worst-case cost
  task automatic queue_cmd(input pfla_pkg::cmd_e c, input logic [ADDR_W-1:0] b,
                           input logic [PAGES_W-1:0] p);
    pending_cmds.push_back('{cmd: c, base: b, pages: p});
    cycle_budget += MAX_GAP + TE + 8;
    case (c)
      pfla_pkg::CMD_CLEAR: live_bound = 0;
      pfla_pkg::CMD_PUSH:  if (live_bound < TE) live_bound++;
      pfla_pkg::CMD_MERGE: cycle_budget += longint'(live_bound + 2) * (TE + 2);
      default: ;
    endcase
  endtask

  task automatic push_beside_cluster(input logic [PAGES_W-1:0] p);
    logic [63:0] span;
    span = 64'(p) * 64'(PB);
    if ($urandom_range(0, 1)) begin
      queue_cmd(pfla_pkg::CMD_PUSH, cluster_hi, p);
      cluster_hi = cluster_hi + span[ADDR_W-1:0];
    end else begin
      cluster_lo = cluster_lo - span[ADDR_W-1:0];
      queue_cmd(pfla_pkg::CMD_PUSH, cluster_lo, p);
    end
  endtask

  // sender: bursts of beats with random gaps after each burst
  always @(posedge clk_i) begin : cmd_driver
    logic go;
    int   roll;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_results.push_back(predict_outcome(pending_cmds[0]));
        pending_cmds.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          roll = $urandom_range(0, 99);
          if (roll < 45) gap_left = 0;
          else if (roll < 75) gap_left = $urandom_range(1, 6);
          else if (roll < 93) gap_left = $urandom_range(7, 80);
          else gap_left = $urandom_range(81, MAX_GAP);
          burst_left = $urandom_range(1, 16);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        go = 1'b0;
      end else begin
        go = pending_cmds.size() > 0;
      end
      if (go) begin
        command_i    <= pending_cmds[0].cmd;
        block_base_i <= pending_cmds[0].base;
        page_count_i <= pending_cmds[0].pages;
      end else begin
        command_i    <= pfla_pkg::CMD_W'($urandom);
        block_base_i <= rand_addr();
        page_count_i <= rand_pages();
      end
      start_i <= go;
    end
  end

  always @(posedge clk_i) begin : result_monitor
    alloc_result_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: success %0b, alloc_address %h",
               success_o, alloc_address_o);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (success_o !== want.success) begin
          $error("success: expected %0b, actual %0b", want.success, success_o);
          mismatches++;
        end
        if (alloc_address_o !== want.addr) begin
          $error("alloc_address: expected %h, actual %h", want.addr, alloc_address_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > cycle_budget) begin
      $display("** page_free_list_allocator_core: FAILED **");
      $finish;
    end
  end

  initial begin
    int roll;
    int n;
    foreach (free_runs[s]) free_runs[s] = '0;

    // directed: empty table, zero pages, wrap, overflow skip, grant at zero, all-ones
    queue_cmd(pfla_pkg::CMD_ALLOC, '0, '0);
    queue_cmd(pfla_pkg::CMD_MERGE, '0, '0);
    queue_cmd(pfla_pkg::CMD_PUSH, '0, '0);
    queue_cmd(pfla_pkg::CMD_ALLOC, '0, '0);
    queue_cmd(pfla_pkg::CMD_ALLOC, '0, 36'd1);
    queue_cmd(pfla_pkg::CMD_PUSH, TOP_PAGE, 36'd2);
    queue_cmd(pfla_pkg::CMD_PUSH, 48'h1000, 36'd3);
    queue_cmd(pfla_pkg::CMD_PUSH, 48'h1_0000, 36'd1);
    queue_cmd(pfla_pkg::CMD_MERGE, '0, '0);
    queue_cmd(pfla_pkg::CMD_ALLOC, ADDR_MAX, 36'd6);
    queue_cmd(pfla_pkg::CMD_ALLOC, '0, 36'd5);
    queue_cmd(pfla_pkg::CMD_ALLOC, '0, 36'd1);
    queue_cmd(pfla_pkg::CMD_PUSH, '0, PAGES_MAX);
    queue_cmd(pfla_pkg::CMD_PUSH, TOP_PAGE, 36'd1);
    queue_cmd(pfla_pkg::CMD_MERGE, '0, '0);
    queue_cmd(pfla_pkg::CMD_ALLOC, '0, PAGES_MAX);
    queue_cmd(pfla_pkg::CMD_ALLOC, '0, 36'd1);
    queue_cmd(pfla_pkg::CMD_PUSH, ADDR_MAX, PAGES_MAX);
    queue_cmd(pfla_pkg::CMD_ALLOC, ADDR_MAX, PAGES_MAX);
    queue_cmd(pfla_pkg::CMD_CLEAR, ADDR_MAX, PAGES_MAX);
    queue_cmd(pfla_pkg::CMD_PUSH, 48'h5000, 36'd2);
    queue_cmd(pfla_pkg::CMD_PUSH, 48'h3000, 36'd2);
    queue_cmd(pfla_pkg::CMD_PUSH, 48'h7000, 36'd1);
    queue_cmd(pfla_pkg::CMD_MERGE, '0, '0);
    queue_cmd(pfla_pkg::CMD_ALLOC, '0, 36'd5);
    queue_cmd(pfla_pkg::CMD_CLEAR, '0, '0);

    // fill the table, overflow it, then merge a full table
    cluster_lo = rand_addr() & ~48'hFFF;
    cluster_hi = cluster_lo;
    for (int k = 0; k < TE; k++) begin
      if ($urandom_range(0, 3) != 0) push_beside_cluster(PAGES_W'($urandom_range(1, 4)));
      else queue_cmd(pfla_pkg::CMD_PUSH, rand_addr() & ~48'hFFF,
                     PAGES_W'($urandom_range(1, 4)));
    end
    queue_cmd(pfla_pkg::CMD_PUSH, rand_addr(), rand_pages());
    queue_cmd(pfla_pkg::CMD_PUSH, rand_addr(), rand_pages());
    for (int k = 0; k < 4; k++) begin
      queue_cmd(pfla_pkg::CMD_ALLOC, rand_addr(), PAGES_W'($urandom_range(1, 6)));
    end
    queue_cmd(pfla_pkg::CMD_MERGE, rand_addr(), rand_pages());
    for (int k = 0; k < 6; k++) begin
      if ($urandom_range(0, 1)) push_beside_cluster(PAGES_W'($urandom_range(1, 8)));
      else queue_cmd(pfla_pkg::CMD_ALLOC, rand_addr(), PAGES_W'($urandom_range(1, 40)));
    end

    // episodes of mostly well-formed traffic around a growing cluster
    while (pending_cmds.size() < NUM_ITEMS) begin
      if ($urandom_range(0, 4) != 0) begin
        queue_cmd(pfla_pkg::CMD_CLEAR, rand_addr(), rand_pages());
        cluster_lo = rand_addr() & ~48'hFFF;
        cluster_hi = cluster_lo;
      end
      n = $urandom_range(4, 24);
      for (int k = 0; k < n; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 38) begin
          push_beside_cluster($urandom_range(0, 9) == 0 ? '0 : PAGES_W'($urandom_range(1, 16)));
        end else if (roll < 46) begin
          if ($urandom_range(0, 1)) push_beside_cluster($urandom_range(0, 1) ? rand_pages()
                                                         : PAGES_W'($urandom_range(1, 64)));
          else queue_cmd(pfla_pkg::CMD_PUSH, rand_addr(), $urandom_range(0, 1) ? rand_pages()
                         : PAGES_W'($urandom_range(1, 64)));
        end else if (roll < 74) begin
          queue_cmd(pfla_pkg::CMD_ALLOC, rand_addr(), PAGES_W'($urandom_range(1, 8)));
        end else if (roll < 80) begin
          queue_cmd(pfla_pkg::CMD_ALLOC, rand_addr(), rand_pages());
        end else if (roll < 83) begin
          queue_cmd(pfla_pkg::CMD_ALLOC, rand_addr(), '0);
        end else if (roll < 91) begin
          queue_cmd(pfla_pkg::CMD_MERGE, rand_addr(), rand_pages());
        end else if (roll < 93) begin
          queue_cmd(pfla_pkg::CMD_CLEAR, rand_addr(), rand_pages());
        end else if (roll < 96) begin
          // restart near the top of the address space so runs wrap
          cluster_lo = TOP_PAGE - ADDR_W'(PB * $urandom_range(0, 8));
          cluster_hi = cluster_lo;
          push_beside_cluster(PAGES_W'($urandom_range(1, 16)));
        end else begin
          queue_cmd(pfla_pkg::CMD_ALLOC, rand_addr(), PAGES_W'($urandom_range(9, 64)));
        end
      end
    end
    cycle_budget = 2 * cycle_budget + 4 * TE + 10000;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (TE + 8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("** page_free_list_allocator_core: PASSED **");
    end else begin
      $display("** page_free_list_allocator_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- page_free_list_allocator_core.f -----
hdl/pfla_pkg.sv
hdl/pfla_mem.sv
hdl/page_free_list_allocator_core.sv
tb/tb_top.sv
